FILE: design/twcr_pkg.sv
package twcr_pkg;

    localparam int TEX_COL_W  = 6;
    localparam int TEX_ROW_W  = 6;
    localparam int TEX_NUM_W  = 2;
    localparam int TEX_ADDR_W = TEX_NUM_W + TEX_ROW_W + TEX_COL_W;
    localparam int TEX_DEPTH  = 1 << TEX_ADDR_W;
    localparam int COLOR_W    = 24;

    localparam int DIVIDEND_W = 41;
    localparam int DIVISOR_W  = 31;

    localparam logic [10:0] MAX_SCREEN_HEIGHT = 11'd1024;
    localparam logic [30:0] PERP_MAX          = 31'h7FFF_FFFF;
    localparam logic [22:0] STEP_NUMERATOR    = 23'd4194304;

    localparam logic [23:0] SHADE_MASK_1 = 24'h787878;
    localparam logic [23:0] SHADE_MASK_2 = 24'h6e6e6e;
    localparam logic [23:0] SHADE_MASK_3 = 24'h5a5a5a;

    localparam logic signed [31:0] SHADE_LIMIT_1 = 32'sd131072;
    localparam logic signed [31:0] SHADE_LIMIT_2 = 32'sd262144;
    localparam logic signed [31:0] SHADE_LIMIT_3 = 32'sd393216;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_COLUMN = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;

    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
    localparam logic [1:0] REG_PLAYER_POS_X  = 2'd1;
    localparam logic [1:0] REG_PLAYER_POS_Y  = 2'd2;

    typedef enum logic [1:0] {
        DIV_PERP,
        DIV_LINE,
        DIV_STEP
    } div_sel_t;

    typedef struct packed {
        logic     tex_write;
        logic     col_latch;
        logic     pix_issue;
        logic     div_start;
        div_sel_t div_sel;
        logic     perp_load;
        logic     line_load;
        logic     step_load;
        logic     mul_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic col_active;
    } status_t;

endpackage

FILE: design/twcr_div.sv
module twcr_div
    import twcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  diff;

    assign rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVISOR_W+1])
            begin
                rem_reg <= diff[DIVISOR_W:0];
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/twcr_datapath.sv
module twcr_datapath
    import twcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic [13:0]        texel_index,
    input  logic [23:0]        texel_color,
    input  logic [9:0]         screen_column,
    input  logic               hit_side,
    input  logic signed [1:0]  grid_step_x,
    input  logic signed [1:0]  grid_step_y,
    input  logic [7:0]         hit_cell_x,
    input  logic [7:0]         hit_cell_y,
    input  logic signed [20:0] ray_dir_x,
    input  logic signed [20:0] ray_dir_y,
    output logic [9:0]         pixel_column,
    output logic [9:0]         pixel_row,
    output logic [23:0]        pixel_color,
    output logic               last_of_column
);

    logic [10:0] screen_height_reg;
    logic [23:0] player_pos_x_reg;
    logic [23:0] player_pos_y_reg;

    logic [COLOR_W-1:0] store [TEX_DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    logic                  col_active_reg;
    logic [9:0]            cur_column_reg;
    logic [9:0]            cur_row_reg;
    logic [9:0]            span_end_reg;
    logic [TEX_NUM_W-1:0]  tex_num_reg;
    logic [TEX_COL_W-1:0]  tex_col_reg;
    logic [31:0]           tex_pos_reg;
    logic [22:0]           tex_step_reg;
    logic [1:0]            shade_reg;

    logic                  side_reg;
    logic signed [1:0]     sx_reg;
    logic signed [1:0]     sy_reg;
    logic signed [20:0]    rx_reg;
    logic signed [20:0]    ry_reg;
    logic [9:0]            col_reg;
    logic signed [25:0]    num_reg;
    logic signed [31:0]    perp_reg;
    logic signed [27:0]    line_reg;
    logic [22:0]           step_reg;
    logic signed [29:0]    k_reg;
    logic [9:0]            row_pend_reg;
    logic [9:0]            end_pend_reg;
    logic                  active_pend_reg;

    logic [9:0]            pcol_reg;
    logic [9:0]            prow_reg;
    logic                  plast_reg;
    logic [9:0]            out_col_reg;
    logic [9:0]            out_row_reg;
    logic [23:0]           out_color_reg;
    logic                  out_last_reg;

    logic [10:0]           h_eff;
    logic [26:0]           h_q16;
    logic [7:0]            cell_sel;
    logic                  step_neg;
    logic [23:0]           pos_sel;
    logic [24:0]           num_base;
    logic signed [25:0]    num_next;
    logic [25:0]           num_neg;
    logic [20:0]           rd_neg;
    logic [20:0]           rd_mag;
    logic [31:0]           perp_neg;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;

    logic [30:0]           perp_mag;
    logic [31:0]           perp_pos;
    logic [27:0]           line_pos;
    logic signed [27:0]    line_half;
    logic [9:0]            half_h;
    logic signed [29:0]    ds_raw;
    logic signed [29:0]    ds;
    logic signed [29:0]    de_raw;
    logic signed [29:0]    de;
    logic signed [29:0]    k_next;

    logic signed [20:0]    ord;
    logic [23:0]           opos;
    logic signed [52:0]    wall_prod;
    logic [31:0]           wall;
    logic [TEX_COL_W-1:0]  tx;
    logic                  mirror;
    logic signed [53:0]    pos_prod;
    logic [TEX_NUM_W-1:0]  tex_num_next;
    logic [1:0]            shade_next;

    logic [TEX_ADDR_W-1:0] rd_addr;
    logic [10:0]           row_plus;
    logic                  last_next;
    logic [23:0]           c1;
    logic [23:0]           c2;
    logic [23:0]           c3;
    logic [23:0]           shaded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_height_reg <= 11'd480;
            player_pos_x_reg  <= '0;
            player_pos_y_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[10:0];
                REG_PLAYER_POS_X:  player_pos_x_reg  <= cfg_data;
                REG_PLAYER_POS_Y:  player_pos_y_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign h_eff = (screen_height_reg > MAX_SCREEN_HEIGHT) ? MAX_SCREEN_HEIGHT
                                                           : screen_height_reg;
    assign h_q16 = {h_eff, 16'd0};

    assign cell_sel = hit_side ? hit_cell_y : hit_cell_x;
    assign step_neg = hit_side ? grid_step_y[1] : grid_step_x[1];
    assign pos_sel  = hit_side ? player_pos_y_reg : player_pos_x_reg;
    assign num_base = {({1'b0, cell_sel} + {8'd0, step_neg}), 16'd0};
    assign num_next = $signed({1'b0, num_base}) - $signed({2'b00, pos_sel});

    function automatic logic [20:0] rx_ry_sel();
        return side_reg ? ry_reg : rx_reg;
    endfunction

    function automatic logic rx_ry_sel_neg();
        return side_reg ? ry_reg[20] : rx_reg[20];
    endfunction

    assign num_neg  = -num_reg;
    assign rd_neg   = -rx_ry_sel();
    assign rd_mag   = rx_ry_sel_neg() ? rd_neg : rx_ry_sel();
    assign perp_neg = -perp_reg;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_PERP:
            begin
                div_dividend = {(num_reg[25] ? num_neg[24:0] : num_reg[24:0]), 16'd0};
                div_divisor  = {10'd0, rd_mag};
            end
            DIV_LINE:
            begin
                div_dividend = {14'd0, h_q16};
                div_divisor  = perp_reg[31] ? perp_neg[30:0] : perp_reg[30:0];
            end
            default:
            begin
                div_dividend = {18'd0, STEP_NUMERATOR};
                div_divisor  = {4'd0, line_reg[26:0]};
            end
        endcase
    end

    twcr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign perp_mag = (div_quo > {10'd0, PERP_MAX}) ? PERP_MAX : div_quo[30:0];
    assign perp_pos = {1'b0, perp_mag};
    assign line_pos = {1'b0, div_quo[26:0]};

    assign line_half = $signed(line_reg + {27'd0, line_reg[27]}) >>> 1;
    assign half_h    = h_eff[10:1];
    assign ds_raw    = $signed({20'd0, half_h}) - 30'(line_half);
    assign ds        = ds_raw[29] ? '0 : ds_raw;
    assign de_raw    = 30'(line_half) + $signed({20'd0, half_h});
    assign de        = (de_raw >= $signed({19'd0, h_eff})) ?
                       ($signed({19'd0, h_eff}) - 30'sd1) : de_raw;
    assign k_next    = ds - $signed({20'd0, half_h}) + 30'(line_half);

    assign ord       = side_reg ? rx_reg : ry_reg;
    assign opos      = side_reg ? player_pos_x_reg : player_pos_y_reg;
    assign wall_prod = perp_reg * ord;
    assign wall      = {opos[15:0], 16'd0} + wall_prod[31:0];
    assign tx        = wall[31 -: TEX_COL_W];
    assign mirror    = (!side_reg && !rx_reg[20] && (rx_reg != '0)) ||
                       (side_reg && ry_reg[20]);
    assign pos_prod  = k_reg * $signed({1'b0, step_reg});

    always_comb
    begin
        tex_num_next = tex_num_reg;
        if (!side_reg && sx_reg == -2'sd1)
            tex_num_next = 2'd0;
        else if (!side_reg && sx_reg == 2'sd1)
            tex_num_next = 2'd1;
        else if (side_reg && sy_reg == -2'sd1)
            tex_num_next = 2'd2;
        else if (side_reg && sy_reg == 2'sd1)
            tex_num_next = 2'd3;
    end

    assign shade_next = 2'(perp_reg > SHADE_LIMIT_1) + 2'(perp_reg > SHADE_LIMIT_2)
                      + 2'(perp_reg > SHADE_LIMIT_3);

    always_ff @(posedge clk)
    begin
        if (cmd.col_latch)
        begin
            side_reg <= hit_side;
            sx_reg   <= grid_step_x;
            sy_reg   <= grid_step_y;
            rx_reg   <= ray_dir_x;
            ry_reg   <= ray_dir_y;
            col_reg  <= screen_column;
            num_reg  <= num_next;
        end
        if (cmd.perp_load)
        begin
            if (rx_ry_sel() == '0)
                perp_reg <= {1'b0, PERP_MAX};
            else if (num_reg[25] ^ rx_ry_sel_neg())
                perp_reg <= -perp_pos;
            else
                perp_reg <= perp_pos;
        end
        if (cmd.line_load)
        begin
            if (perp_reg == '0)
                line_reg <= {1'b0, h_q16};
            else if (perp_reg[31])
                line_reg <= -line_pos;
            else
                line_reg <= line_pos;
        end
        if (cmd.step_load)
        begin
            step_reg        <= (!line_reg[27] && line_reg != '0) ? div_quo[22:0] : '0;
            k_reg           <= k_next;
            row_pend_reg    <= ds[9:0];
            end_pend_reg    <= de[29] ? '0 : de[9:0];
            active_pend_reg <= ds < de;
        end
    end

    assign rd_addr  = {tex_num_reg, tex_pos_reg[16 +: TEX_ROW_W], tex_col_reg};
    assign row_plus = {1'b0, cur_row_reg} + 11'd1;
    assign last_next = row_plus >= {1'b0, span_end_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_active_reg <= 1'b0;
            cur_column_reg <= '0;
            cur_row_reg    <= '0;
            span_end_reg   <= '0;
            tex_num_reg    <= '0;
            tex_col_reg    <= '0;
            tex_pos_reg    <= '0;
            tex_step_reg   <= '0;
            shade_reg      <= '0;
        end
        else if (cmd.mul_load)
        begin
            col_active_reg <= active_pend_reg;
            cur_column_reg <= col_reg;
            cur_row_reg    <= row_pend_reg;
            span_end_reg   <= end_pend_reg;
            tex_num_reg    <= tex_num_next;
            tex_col_reg    <= mirror ? ~tx : tx;
            tex_pos_reg    <= pos_prod[31:0];
            tex_step_reg   <= step_reg;
            shade_reg      <= shade_next;
        end
        else if (cmd.pix_issue)
        begin
            tex_pos_reg <= tex_pos_reg + {9'd0, tex_step_reg};
            cur_row_reg <= row_plus[9:0];
            if (last_next)
                col_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tex_write)
            store[texel_index] <= texel_color;
        if (cmd.pix_issue)
        begin
            rdata_reg <= store[rd_addr];
            pcol_reg  <= cur_column_reg;
            prow_reg  <= cur_row_reg;
            plast_reg <= last_next;
        end
    end

    assign c1 = (rdata_reg >> 1) & SHADE_MASK_1;
    assign c2 = (c1 >> 1) & SHADE_MASK_2;
    assign c3 = (c2 >> 1) & SHADE_MASK_3;

    always_comb
    begin
        case (shade_reg)
            2'd0:    shaded = rdata_reg;
            2'd1:    shaded = c1;
            2'd2:    shaded = c2;
            default: shaded = c3;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_col_reg   <= pcol_reg;
            out_row_reg   <= prow_reg;
            out_color_reg <= shaded;
            out_last_reg  <= plast_reg;
        end
    end

    assign status.div_done   = div_done;
    assign status.col_active = col_active_reg;

    assign pixel_column   = out_col_reg;
    assign pixel_row      = out_row_reg;
    assign pixel_color    = out_color_reg;
    assign last_of_column = out_last_reg;

endmodule

FILE: design/twcr_ctrl.sv
module twcr_ctrl
    import twcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] action,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output cmd_t       cmd,
    input  status_t    status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERP_GO,
        ST_PERP_WAIT,
        ST_LINE_GO,
        ST_LINE_WAIT,
        ST_STEP_GO,
        ST_STEP_WAIT,
        ST_MUL,
        ST_PIX
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_PERP;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_LOAD:   cmd.tex_write = 1'b1;
                        ACT_COLUMN:
                        begin
                            cmd.col_latch = 1'b1;
                            state_next    = ST_PERP_GO;
                        end
                        ACT_PIXEL:
                        begin
                            if (status.col_active)
                            begin
                                cmd.pix_issue = 1'b1;
                                state_next    = ST_PIX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PERP_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_PERP_WAIT;
            end
            ST_PERP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.perp_load = 1'b1;
                    state_next    = ST_LINE_GO;
                end
            end
            ST_LINE_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_LINE;
                state_next    = ST_LINE_WAIT;
            end
            ST_LINE_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.line_load = 1'b1;
                    state_next    = ST_STEP_GO;
                end
            end
            ST_STEP_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STEP;
                state_next    = ST_STEP_WAIT;
            end
            ST_STEP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.step_load = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_PIX:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = cmd.out_load ? 1'b1 : (out_stall && out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/textured_wall_column_render.sv
// Wall column renderer for a grid raycaster. Items are taken one at a time:
// a pixel item reads the texture memory, then shades into the output
// register, and a column set-up makes three passes through one shared
// radix-2 divider of 41 steps (perpendicular distance, line height, texture
// step) plus a multiply step. A pixel item with no active column is dropped.
// The next item is taken while a finished pixel still waits on out_stall.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user
// must do so only while the block is idle, as the block does not enforce it.
module textured_wall_column_render
    import twcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [13:0]        texel_index,
    input  logic [23:0]        texel_color,
    input  logic [9:0]         screen_column,
    input  logic               hit_side,
    input  logic signed [1:0]  grid_step_x,
    input  logic signed [1:0]  grid_step_y,
    input  logic [7:0]         hit_cell_x,
    input  logic [7:0]         hit_cell_y,
    input  logic signed [20:0] ray_dir_x,
    input  logic signed [20:0] ray_dir_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         pixel_column,
    output logic [9:0]         pixel_row,
    output logic [23:0]        pixel_color,
    output logic               last_of_column
);

    cmd_t    cmd;
    status_t status;

    twcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    twcr_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .texel_index    (texel_index),
        .texel_color    (texel_color),
        .screen_column  (screen_column),
        .hit_side       (hit_side),
        .grid_step_x    (grid_step_x),
        .grid_step_y    (grid_step_y),
        .hit_cell_x     (hit_cell_x),
        .hit_cell_y     (hit_cell_y),
        .ray_dir_x      (ray_dir_x),
        .ray_dir_y      (ray_dir_y),
        .pixel_column   (pixel_column),
        .pixel_row      (pixel_row),
        .pixel_color    (pixel_color),
        .last_of_column (last_of_column)
    );

endmodule

FILE: design/twcr_check.sv
module twcr_check
    import twcr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_stall,
    input logic [9:0]  pixel_row,
    input logic [23:0] pixel_color
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("item dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(pixel_row) && $stable(pixel_color))
        else $error("stalled item changed");

    a_column_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_COLUMN |=> in_stall)
        else $error("column set-up did not hold input");

    a_pixel_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && action == ACT_PIXEL, 2))
        else $error("result without pixel item");

endmodule

bind textured_wall_column_render twcr_check u_check (.*);

FILE: tb/tb.sv
module tb;
    import twcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 6000;
    localparam int SETTLE      = 200;
    localparam int RANDOM_ITEMS = 250;
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [9:0]  column;
        logic [9:0]  row;
        logic [23:0] color;
        logic        last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = REG_SCREEN_HEIGHT;
    logic [23:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = ACT_LOAD;
    logic [13:0] texel_index = '0;
    logic [23:0] texel_color = '0;
    logic [9:0] screen_column = '0;
    logic hit_side = 1'b0;
    logic signed [1:0] grid_step_x = '0;
    logic signed [1:0] grid_step_y = '0;
    logic [7:0] hit_cell_x = '0;
    logic [7:0] hit_cell_y = '0;
    logic signed [20:0] ray_dir_x = '0;
    logic signed [20:0] ray_dir_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
    logic [23:0] pixel_color;
    logic last_of_column;

    textured_wall_column_render u_top (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted block state
    logic [23:0] texels [TEX_DEPTH];
    bit          texel_written [TEX_DEPTH];
    longint      view_height = 480;
    longint      view_x = 0;
    longint      view_y = 0;
    bit          span_open = 0;
    logic [9:0]  span_column = '0;
    longint      row_next = 0;
    longint      row_stop = 0;
    logic [1:0]  wall_texture = '0;
    logic [5:0]  wall_u = '0;
    logic [31:0] wall_v = '0;
    logic [31:0] wall_v_step = '0;
    int          fog_level = 0;

    pixel_t pending_pixels[$];
    int     errors = 0;
    int     pixels_seen = 0;
    int     items_sent = 0;
    int     columns_sent = 0;
    int     idle_cycles = 0;
    bit     quiet_sender = 0;
    bit     quiet_receiver = 0;
    int     stall_left = 0;

    function automatic void setup_column(longint side, longint sx, longint sy, longint mx,
                                         longint my, longint rx, longint ry,
                                         logic [9:0] scol);
        longint h, map_cell, stp, pos, rd, num, perp, lh, half_h, ds, de, wall, k, vstep;
        logic [31:0] frac;
        logic [5:0] tx;
        h = (view_height > 1024) ? 1024 : view_height;
        map_cell = side ? my : mx;
        stp = side ? sy : sx;
        pos = side ? view_y : view_x;
        rd = side ? ry : rx;
        num = (map_cell + ((stp < 0) ? 1 : 0)) * 65536 - pos;
        if (rd == 0)
            perp = 2147483647;
        else
        begin
            perp = (num * 65536) / rd;
            if (perp > 2147483647)
                perp = 2147483647;
            if (perp < -2147483647)
                perp = -2147483647;
        end
        lh = (perp == 0) ? h * 65536 : (h * 65536) / perp;
        half_h = h / 2;
        ds = half_h - lh / 2;
        if (ds < 0)
            ds = 0;
        de = lh / 2 + half_h;
        if (de >= h)
            de = h - 1;
        if (side == 0 && sx == -1)
            wall_texture = 2'd0;
        else if (side == 0 && sx == 1)
            wall_texture = 2'd1;
        else if (side == 1 && sy == -1)
            wall_texture = 2'd2;
        else if (side == 1 && sy == 1)
            wall_texture = 2'd3;
        wall = (side ? view_x : view_y) * 65536 + perp * (side ? rx : ry);
        frac = wall[31:0];
        tx = frac[31:26];
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
            tx = 6'd63 - tx;
        wall_u = tx;
        vstep = (lh > 0) ? 4194304 / lh : 0;
        wall_v_step = vstep[31:0];
        k = ds - half_h + lh / 2;
        k = k * vstep;
        wall_v = k[31:0];
        fog_level = int'(perp > 131072) + int'(perp > 262144) + int'(perp > 393216);
        span_column = scol;
        row_next = ds;
        row_stop = (de < 0) ? 0 : de;
        span_open = ds < de;
    endfunction

    function automatic logic [13:0] next_texel_addr();
        return {wall_texture, wall_v[21:16], wall_u};
    endfunction

    function automatic void emit_pixel();
        pixel_t p;
        logic [23:0] c;
        c = texels[next_texel_addr()];
        wall_v = wall_v + wall_v_step;
        if (fog_level >= 1)
            c = (c >> 1) & SHADE_MASK_1;
        if (fog_level >= 2)
            c = (c >> 1) & SHADE_MASK_2;
        if (fog_level >= 3)
            c = (c >> 1) & SHADE_MASK_3;
        p.column = span_column;
        p.row = row_next[9:0];
        p.color = c;
        row_next++;
        p.last = row_next >= row_stop;
        if (p.last)
            span_open = 0;
        pending_pixels.push_back(p);
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [13:0] idx,
                             input logic [23:0] colr, input logic [9:0] scol,
                             input logic side, input logic [1:0] sx, input logic [1:0] sy,
                             input logic [7:0] mx, input logic [7:0] my,
                             input logic [20:0] rx, input logic [20:0] ry);
        int r;
        int gap;
        in_valid <= 1'b1;
        action <= act;
        texel_index <= idx;
        texel_color <= colr;
        screen_column <= scol;
        hit_side <= side;
        grid_step_x <= sx;
        grid_step_y <= sy;
        hit_cell_x <= mx;
        hit_cell_y <= my;
        ray_dir_x <= rx;
        ray_dir_y <= ry;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        if (act == ACT_LOAD)
        begin
            texels[idx] = colr;
            texel_written[idx] = 1;
        end
        else if (act == ACT_COLUMN)
        begin
            columns_sent++;
            setup_column(longint'(side), longint'($signed(sx)), longint'($signed(sy)),
                         longint'(mx), longint'(my), longint'($signed(rx)),
                         longint'($signed(ry)), scol);
        end
        else if (act == ACT_PIXEL && span_open)
            emit_pixel();
        r = $urandom_range(0, 19);
        gap = 0;
        if (!quiet_sender)
        begin
            if (r >= 19)
                gap = $urandom_range(10, 40);
            else if (r >= 12)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_texel(input logic [13:0] idx, input logic [23:0] colr);
        send_item(ACT_LOAD, idx, colr, 10'($urandom), 1'($urandom), 2'($urandom),
                  2'($urandom), 8'($urandom), 8'($urandom), 21'($urandom), 21'($urandom));
    endtask

    // fill the texel about to be read so no unwritten entry is ever fetched
    task automatic send_pixel();
        if (span_open && !texel_written[next_texel_addr()])
            load_texel(next_texel_addr(), 24'($urandom));
        send_item(ACT_PIXEL, 14'($urandom), 24'($urandom), 10'($urandom), 1'($urandom),
                  2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom), 21'($urandom),
                  21'($urandom));
    endtask

    task automatic send_column(input logic [9:0] scol, input logic side, input logic [1:0] sx,
                               input logic [1:0] sy, input logic [7:0] mx, input logic [7:0] my,
                               input logic [20:0] rx, input logic [20:0] ry, input int extra);
        quiet_sender = ($urandom_range(0, 3) == 0);
        send_item(ACT_COLUMN, 14'($urandom), 24'($urandom), scol, side, sx, sy, mx, my, rx, ry);
        while (span_open)
            send_pixel();
        repeat (extra) send_pixel();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_SCREEN_HEIGHT)
            view_height = longint'(val[10:0]);
        else if (idx == REG_PLAYER_POS_X)
            view_x = longint'(val);
        else if (idx == REG_PLAYER_POS_Y)
            view_y = longint'(val);
    endtask

    task automatic random_column();
        logic side;
        logic [1:0] s;
        logic [1:0] so;
        longint base;
        longint map_cell;
        int mag;
        logic [20:0] rd;
        logic [7:0] c8;
        if ($urandom_range(0, 9) == 0)
        begin
            send_column(10'($urandom), 1'($urandom), 2'($urandom), 2'($urandom),
                        8'($urandom), 8'($urandom), 21'($urandom), 21'($urandom),
                        $urandom_range(0, 2));
            return;
        end
        side = 1'($urandom);
        s = $urandom_range(0, 1) ? 2'b01 : 2'b11;
        so = $urandom_range(0, 1) ? 2'b01 : 2'b11;
        base = (side ? view_y : view_x) >> 16;
        map_cell = base + (s == 2'b01 ? 1 : -1) * $urandom_range(1, 6);
        c8 = map_cell[7:0];
        mag = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1048575)
                                        : $urandom_range(16384, 1048575);
        rd = 21'((s == 2'b01) ? mag : -mag);
        if (side)
            send_column(10'($urandom), side, so, s, 8'($urandom), c8, 21'($urandom), rd,
                        $urandom_range(0, 1));
        else
            send_column(10'($urandom), side, s, so, c8, 8'($urandom), rd, 21'($urandom),
                        $urandom_range(0, 1));
    endtask

    task automatic test_directed();
        write_reg(REG_SCREEN_HEIGHT, 24'd16);
        write_reg(REG_PLAYER_POS_X, 24'h058000);
        write_reg(REG_PLAYER_POS_Y, 24'h034000);
        load_texel(14'd0, 24'hFFFFFF);
        load_texel(14'h3FFF, 24'h000000);
        load_texel(14'h2AAA, 24'hA5A5A5);
        load_texel(14'h1555, 24'h5A5A5A);
        send_pixel();
        // zero ray component
        send_column(10'd0, 1'b0, 2'b01, 2'b01, 8'd7, 8'd3, 21'd0, 21'd1000, 1);
        // near walls on each face
        send_column(10'd1023, 1'b0, 2'b01, 2'b11, 8'd6, 8'd3, 21'd65536, 21'h1FFFFF, 1);
        send_column(10'd1, 1'b0, 2'b11, 2'b01, 8'd4, 8'd3, -21'd65536, 21'd20000, 0);
        send_column(10'd2, 1'b1, 2'b01, 2'b01, 8'd5, 8'd4, 21'd3000, 21'd65536, 0);
        send_column(10'd3, 1'b1, 2'b01, 2'b11, 8'd5, 8'd2, 21'd3000, -21'd65536, 0);
        // far wall, extreme cells and directions
        send_column(10'd4, 1'b0, 2'b01, 2'b01, 8'd255, 8'd0, 21'h0FFFFF, 21'h100000, 1);
        send_column(10'd5, 1'b1, 2'b11, 2'b11, 8'd0, 8'd0, 21'h100000, 21'h100000, 0);
        // step neither plus nor minus one
        send_column(10'd6, 1'b0, 2'b00, 2'b10, 8'd6, 8'd3, 21'd65536, 21'd1, 0);
        send_column(10'd7, 1'b1, 2'b10, 2'b00, 8'd6, 8'd4, 21'd9, 21'd65536, 0);
        // negative distance
        send_column(10'd8, 1'b0, 2'b01, 2'b01, 8'd2, 8'd3, 21'd65536, 21'd0, 1);
        // column replaced mid-span
        send_item(ACT_COLUMN, 14'($urandom), 24'($urandom), 10'd9, 1'b0, 2'b01, 2'b01,
                  8'd6, 8'd3, 21'd65536, 21'd500);
        send_pixel();
        send_pixel();
        send_column(10'd10, 1'b0, 2'b11, 2'b01, 8'd5, 8'd3, -21'd65536, 21'd500, 0);
        send_item(ACT_UNKNOWN, 14'($urandom), 24'($urandom), 10'($urandom), 1'($urandom),
                  2'($urandom), 2'($urandom), 8'($urandom), 8'($urandom), 21'($urandom),
                  21'($urandom));
        // zero distance
        write_reg(REG_PLAYER_POS_X, 24'h050000);
        send_column(10'd11, 1'b0, 2'b01, 2'b01, 8'd5, 8'd3, 21'd40000, 21'd7, 0);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_SCREEN_HEIGHT, 24'd1);
        write_reg(REG_PLAYER_POS_X, 24'h000000);
        send_column(10'd20, 1'b0, 2'b01, 2'b01, 8'd1, 8'd0, 21'd65536, 21'd1, 1);
        write_reg(REG_SCREEN_HEIGHT, 24'd2047);
        write_reg(REG_PLAYER_POS_X, 24'hFFFFFF);
        write_reg(REG_PLAYER_POS_Y, 24'hFFFFFF);
        send_column(10'd21, 1'b0, 2'b11, 2'b01, 8'd250, 8'd3, -21'd65536, 21'd77, 0);
        write_reg(REG_SCREEN_HEIGHT, 24'd1024);
        send_column(10'd22, 1'b1, 2'b01, 2'b11, 8'd3, 8'd240, 21'd5, -21'd65536, 0);
        write_reg(REG_PLAYER_POS_Y, 24'h000000);
    endtask

    task automatic test_random_frames();
        int heights[4] = '{12, 24, 40, 64};
        int start;
        int n;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            quiet_receiver = ($urandom_range(0, 3) == 0);
            write_reg(REG_SCREEN_HEIGHT, 24'(heights[$urandom_range(0, 3)]));
            write_reg(REG_PLAYER_POS_X, 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(REG_PLAYER_POS_Y, 24'($urandom_range(0, 24'hFFFFFF)));
            n = $urandom_range(2, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                    load_texel(14'($urandom), 24'($urandom));
                random_column();
            end
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                pixels_seen++;
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel col %0d row %0d color %h last %b", $time,
                             pixel_column, pixel_row, pixel_color, last_of_column);
                    errors++;
                end
                else
                begin
                    pixel_t e;
                    e = pending_pixels.pop_front();
                    if (pixel_column !== e.column)
                    begin
                        $display("%0t: pixel_column expected %0d got %0d", $time, e.column,
                                 pixel_column);
                        errors++;
                    end
                    if (pixel_row !== e.row)
                    begin
                        $display("%0t: pixel_row expected %0d got %0d", $time, e.row, pixel_row);
                        errors++;
                    end
                    if (pixel_color !== e.color)
                    begin
                        $display("%0t: pixel_color expected %h got %h", $time, e.color,
                                 pixel_color);
                        errors++;
                    end
                    if (last_of_column !== e.last)
                    begin
                        $display("%0t: last_of_column expected %b got %b", $time, e.last,
                                 last_of_column);
                        errors++;
                    end
                end
            end
            if (quiet_receiver)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 29) == 0)
                    stall_left <= $urandom_range(10, 40);
                else if ($urandom_range(0, 3) == 0)
                    stall_left <= $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random_frames();
        drain();
        $display("covered %0d items, %0d column set-ups, %0d pixels checked", items_sent,
                 columns_sent, pixels_seen);
        $display("screen heights from 1 to 2047, viewer at both ends of the map");
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
design/twcr_pkg.sv
design/twcr_div.sv
design/twcr_datapath.sv
design/twcr_ctrl.sv
design/textured_wall_column_render.sv
design/twcr_check.sv
tb/tb.sv
